/* src/hsdl_pkg.sv */
// Shared types, constants and coefficient tables of the hall sensor linearizer.
package hsdl_pkg;

  localparam int SMP_W      = 12;
  localparam int LVL_W      = 12;
  localparam int DIST_W     = 16;
  localparam int PORT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int WINDOW_DEF = 16;
  localparam int NUM_PORTS  = 5;

  // Curve argument index+3 and its log2 in Q4.16.
  localparam int X_W        = 13;
  localparam int N_W        = 4;
  localparam int LOG_FRAC_W = 16;
  localparam int LOG_W      = N_W + LOG_FRAC_W;
  localparam int M_W        = 31;
  localparam int RND_W      = 4;

  // Coefficients in Q.24, exponent and series widths.
  localparam int COEF_A_W   = 30;
  localparam int COEF_B_W   = 23;
  localparam int E_SHIFT    = 16;
  localparam int E_W        = COEF_B_W + LOG_W - E_SHIFT;
  localparam int F_W        = 24;
  localparam int K_W        = E_W - F_W;
  localparam int Q32_W      = 32;
  localparam int ACC_W      = 35;
  localparam int OMY_W      = 33;
  localparam int PROD_W     = COEF_A_W + OMY_W;
  localparam int DIST_SHIFT = 46;
  localparam int J_W        = 4;

  // One shared multiplier serves every product of the curve evaluation but the quotient check by j.
  localparam int MUL_X_W    = 33;
  localparam int MUL_Y_W    = 32;
  localparam int MUL_P_W    = MUL_X_W + MUL_Y_W;

  localparam logic [Q32_W-1:0] LN2_Q32   = 32'd2977044472;
  localparam logic [RND_W-1:0] LOG_LAST  = 4'd15;
  localparam logic [J_W-1:0]   TERM_ONE  = 4'd1;
  localparam logic [J_W-1:0]   TERM_LAST = 4'd14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PORT_SELECT,
    CFG_MIN_LEVEL,
    CFG_MAX_LEVEL,
    CFG_OP_MAX_LEVEL
  } cfg_idx_t;

  typedef struct packed {
    logic [PORT_W-1:0] port_sel;
    logic [LVL_W-1:0]  min_lvl;
    logic [LVL_W-1:0]  max_lvl;
    logic [LVL_W-1:0]  opmax_lvl;
  } cfg_t;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [LVL_W-1:0]  averaged_level;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RING,
    S_MEAN,
    S_INDEX,
    S_NORM,
    S_LOG,
    S_EXP_MUL,
    S_T_MUL,
    S_TERM_ACC,
    S_TERM_MUL,
    S_TERM_RCP,
    S_TERM_COR,
    S_FIN_Y,
    S_FIN_MUL,
    S_FIN_RND,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_SQ,
    MUL_EXP,
    MUL_T,
    MUL_TERM,
    MUL_RCP,
    MUL_FIN
  } mul_sel_t;

  typedef struct packed {
    logic     start;
    logic     ring;
    logic     mean;
    logic     index;
    logic     norm;
    logic     log_step;
    logic     exp_mul;
    logic     t_mul;
    logic     term_acc;
    logic     term_mul;
    logic     term_rcp;
    logic     term_cor;
    logic     fin_y;
    logic     fin_mul;
    logic     fin_rnd;
    logic     load_out;
    mul_sel_t mul_sel;
  } cmd_t;

  typedef struct packed {
    logic log_last;
    logic term_last;
  } stat_t;

  // Scale a of each calibrated port, round(a * 2^24).
  function automatic logic [COEF_A_W-1:0] coef_a(input logic [PORT_W-1:0] port);
    logic [COEF_A_W-1:0] val;
    unique case (port)
      3'd0:    val = 30'd771062460;
      3'd1:    val = 30'd762131964;
      3'd2:    val = 30'd767691346;
      3'd3:    val = 30'd761244366;
      3'd4:    val = 30'd775312229;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Magnitude of the exponent b of each port, round(|b| * 2^24).
  function automatic logic [COEF_B_W-1:0] coef_b(input logic [PORT_W-1:0] port);
    logic [COEF_B_W-1:0] val;
    unique case (port)
      3'd0:    val = 23'd7544245;
      3'd1:    val = 23'd7454726;
      3'd2:    val = 23'd7509628;
      3'd3:    val = 23'd7455176;
      3'd4:    val = 23'd7574265;
      default: val = '0;
    endcase
    return val;
  endfunction

  // floor(2^32 / j); the quotient estimate from it is low by at most one.
  function automatic logic [Q32_W-1:0] recip_q32(input logic [J_W-1:0] j);
    logic [Q32_W-1:0] val;
    unique case (j)
      4'd2:    val = 32'd2147483648;
      4'd3:    val = 32'd1431655765;
      4'd4:    val = 32'd1073741824;
      4'd5:    val = 32'd858993459;
      4'd6:    val = 32'd715827882;
      4'd7:    val = 32'd613566756;
      4'd8:    val = 32'd536870912;
      4'd9:    val = 32'd477218588;
      4'd10:   val = 32'd429496729;
      4'd11:   val = 32'd390451572;
      4'd12:   val = 32'd357913941;
      4'd13:   val = 32'd330382099;
      4'd14:   val = 32'd306783378;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* src/hsdl_stream_if.sv */
// Valid/ready stream channel carrying one item of a given payload type.
interface hsdl_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/hsdl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hsdl_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* src/hsdl_cfg_regs.sv */
// Configuration register file written through the plain write port.
module hsdl_cfg_regs
  import hsdl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);
  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PORT_SELECT:  cfg_nxt.port_sel  = cfg_wdata[PORT_W-1:0];
        CFG_MIN_LEVEL:    cfg_nxt.min_lvl   = cfg_wdata[LVL_W-1:0];
        CFG_MAX_LEVEL:    cfg_nxt.max_lvl   = cfg_wdata[LVL_W-1:0];
        CFG_OP_MAX_LEVEL: cfg_nxt.opmax_lvl = cfg_wdata[LVL_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.port_sel  <= '0;
      cfg_r.min_lvl   <= '0;
      cfg_r.max_lvl   <= '1;
      cfg_r.opmax_lvl <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

/* src/hsdl_ctrl.sv */
// Sequencer that steps the datapath through ring update, log, series and scaling.
module hsdl_ctrl
  import hsdl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // The output register takes a new item once the old one is gone or leaving.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_RING;
      S_RING:     state_nxt = S_MEAN;
      S_MEAN:     state_nxt = S_INDEX;
      S_INDEX:    state_nxt = S_NORM;
      S_NORM:     state_nxt = S_LOG;
      S_LOG:      if (stat.log_last) state_nxt = S_EXP_MUL;
      S_EXP_MUL:  state_nxt = S_T_MUL;
      S_T_MUL:    state_nxt = S_TERM_ACC;
      S_TERM_ACC: state_nxt = stat.term_last ? S_FIN_Y : S_TERM_MUL;
      S_TERM_MUL: state_nxt = S_TERM_RCP;
      S_TERM_RCP: state_nxt = S_TERM_COR;
      S_TERM_COR: state_nxt = S_TERM_ACC;
      S_FIN_Y:    state_nxt = S_FIN_MUL;
      S_FIN_MUL:  state_nxt = S_FIN_RND;
      S_FIN_RND:  state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_SQ;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_RING:  cmd.ring  = 1'b1;
      S_MEAN:  cmd.mean  = 1'b1;
      S_INDEX: cmd.index = 1'b1;
      S_NORM:  cmd.norm  = 1'b1;
      S_LOG: begin
        cmd.log_step = 1'b1;
        cmd.mul_sel  = MUL_SQ;
      end
      S_EXP_MUL: begin
        cmd.exp_mul = 1'b1;
        cmd.mul_sel = MUL_EXP;
      end
      S_T_MUL: begin
        cmd.t_mul   = 1'b1;
        cmd.mul_sel = MUL_T;
      end
      S_TERM_ACC: cmd.term_acc = 1'b1;
      S_TERM_MUL: begin
        cmd.term_mul = 1'b1;
        cmd.mul_sel  = MUL_TERM;
      end
      S_TERM_RCP: begin
        cmd.term_rcp = 1'b1;
        cmd.mul_sel  = MUL_RCP;
      end
      S_TERM_COR: cmd.term_cor = 1'b1;
      S_FIN_Y:    cmd.fin_y    = 1'b1;
      S_FIN_MUL: begin
        cmd.fin_mul = 1'b1;
        cmd.mul_sel = MUL_FIN;
      end
      S_FIN_RND: cmd.fin_rnd  = 1'b1;
      S_DONE:    cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

/* src/hsdl_dp.sv */
// Datapath: sample ring with running sum, level clamp, fixed-point power curve.
module hsdl_dp
  import hsdl_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  cfg_t             cfg,
  input  logic [SMP_W-1:0] in_sample,
  output out_item_t        out_item
);
  localparam int PTR_W = $clog2(WINDOW);
  localparam int SUM_W = SMP_W + PTR_W;
  localparam int IDX_W = LVL_W + 2;
  localparam int EPROD_W = COEF_B_W + LOG_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic signed [IDX_W-1:0] IDX_ONE = IDX_W'(1);
  localparam logic signed [IDX_W-1:0] IDX_MAX = IDX_W'(1 << LVL_W);
  localparam logic [X_W-1:0] X_OFS = X_W'(3);
  localparam logic signed [ACC_W-1:0] ACC_ONE =
    {{(ACC_W-Q32_W-1){1'b0}}, 1'b1, {Q32_W{1'b0}}};
  localparam logic [ACC_W-2:0] Y_ONE = {{(ACC_W-Q32_W-2){1'b0}}, 1'b1, {Q32_W{1'b0}}};
  localparam logic [OMY_W-1:0] OMY_ONE = {1'b1, {Q32_W{1'b0}}};
  localparam logic [EPROD_W-1:0] E_HALF = EPROD_W'(1) << (E_SHIFT - 1);
  localparam logic [PROD_W-1:0] D_HALF = PROD_W'(1) << (DIST_SHIFT - 1);

  // Ring and running sum.
  logic [SMP_W-1:0]  smp_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PTR_W-1:0]  wpos_r, wpos_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [SMP_W-1:0]  ram_rdata;
  logic [SMP_W-1:0]  old_smp;

  // Level and curve argument.
  logic [LVL_W-1:0]  mean_r, mean_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic signed [IDX_W-1:0] d_lvl, d_max, idx;

  // Logarithm.
  logic [N_W-1:0]        n_r, msb;
  logic [M_W-1:0]        m_r, m_nxt;
  logic [LOG_FRAC_W-1:0] frac_r, frac_nxt;
  logic [RND_W-1:0]      rnd_r, rnd_nxt;
  logic [Q32_W-1:0]      sq;
  logic [LOG_W-1:0]      log_q16;

  // Exponent and series.
  logic [E_W-1:0]          e_r;
  logic [EPROD_W-1:0]      e_sum;
  logic [Q32_W-1:0]        t_r;
  logic [Q32_W-1:0]        term_r, term_nxt;
  logic [Q32_W-1:0]        p_r;
  logic [Q32_W-1:0]        q0_r;
  logic [J_W-1:0]          j_r, j_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] term_s;
  logic [Q32_W+J_W-1:0]    qj, rem;

  // Final scaling.
  logic [ACC_W-2:0]  acc_pos, y_sh;
  logic [OMY_W-1:0]  y_cl;
  logic [OMY_W-1:0]  omy_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_rnd;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [DIST_W-1:0] out_dist_r;
  logic [LVL_W-1:0]  out_avg_r;

  // Shared multiplier.
  logic [MUL_X_W-1:0] mul_x;
  logic [MUL_Y_W-1:0] mul_y;
  logic [MUL_P_W-1:0] mul_p;

  hsdl_ram #(
    .WIDTH (SMP_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.ring),
    .waddr (wpos_r),
    .wdata (smp_r),
    .raddr (wpos_r),
    .rdata (ram_rdata)
  );

  assign log_q16 = {n_r, frac_r};

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (cmd.mul_sel)
      MUL_SQ: begin
        mul_x = MUL_X_W'(m_r);
        mul_y = MUL_Y_W'(m_r);
      end
      MUL_EXP: begin
        mul_x = MUL_X_W'(log_q16);
        mul_y = MUL_Y_W'(coef_b(cfg.port_sel));
      end
      MUL_T: begin
        mul_x = MUL_X_W'(e_r[F_W-1:0]);
        mul_y = LN2_Q32;
      end
      MUL_TERM: begin
        mul_x = MUL_X_W'(term_r);
        mul_y = t_r;
      end
      MUL_RCP: begin
        mul_x = MUL_X_W'(p_r);
        mul_y = recip_q32(j_r);
      end
      MUL_FIN: begin
        mul_x = omy_r;
        mul_y = MUL_Y_W'(coef_a(cfg.port_sel));
      end
      default: ;
    endcase
  end

  assign mul_p = MUL_P_W'(mul_x) * MUL_P_W'(mul_y);

  // Until the pointer has wrapped once, the slot being replaced was never written.
  assign old_smp     = wrapped_r ? ram_rdata : '0;
  assign sum_nxt     = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
  assign wpos_nxt    = wpos_r + PTR_W'(1);
  assign wrapped_nxt = wrapped_r | (wpos_r == PTR_LAST);

  always_comb begin
    mean_nxt = sum_r[SUM_W-1:PTR_W];
    lvl_nxt  = (mean_nxt < cfg.min_lvl) ? cfg.min_lvl : mean_nxt;
    if (lvl_nxt > cfg.opmax_lvl) begin
      lvl_nxt = cfg.opmax_lvl;
    end
  end

  always_comb begin
    d_lvl = $signed({2'b00, lvl_r}) - $signed({2'b00, cfg.min_lvl}) + IDX_ONE;
    d_max = $signed({2'b00, cfg.max_lvl}) - $signed({2'b00, cfg.min_lvl}) + IDX_ONE;
    idx   = (lvl_r >= cfg.max_lvl) ? d_max : d_lvl;
    if (idx < IDX_ONE) begin
      idx = IDX_ONE;
    end
    if (idx > IDX_MAX) begin
      idx = IDX_MAX;
    end
    x_nxt = idx[X_W-1:0] + X_OFS;
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x_r[i]) begin
        msb = N_W'(i);
      end
    end
  end

  // One squaring round of the log fraction: a product at or above two yields a 1 bit.
  always_comb begin
    sq       = mul_p[2*M_W-1:M_W-1];
    m_nxt    = sq[Q32_W-1] ? sq[Q32_W-1:1] : sq[M_W-1:0];
    frac_nxt = {frac_r[LOG_FRAC_W-2:0], sq[Q32_W-1]};
    rnd_nxt  = rnd_r + RND_W'(1);
  end

  assign e_sum = mul_p[EPROD_W-1:0] + E_HALF;

  always_comb begin
    qj       = (Q32_W+J_W)'(q0_r) * (Q32_W+J_W)'(j_r);
    rem      = (Q32_W+J_W)'(p_r) - qj;
    term_nxt = (rem >= (Q32_W+J_W)'(j_r)) ? q0_r + Q32_W'(1) : q0_r;
  end

  // Odd terms of the series for e^-t are subtracted.
  always_comb begin
    term_s  = $signed({{(ACC_W-Q32_W){1'b0}}, term_r});
    acc_nxt = j_r[0] ? acc_r - term_s : acc_r + term_s;
    j_nxt   = j_r + J_W'(1);
  end

  always_comb begin
    acc_pos = acc_r[ACC_W-1] ? '0 : acc_r[ACC_W-2:0];
    y_sh    = acc_pos >> e_r[E_W-1:F_W];
    y_cl    = (y_sh > Y_ONE) ? Y_ONE[OMY_W-1:0] : y_sh[OMY_W-1:0];
  end

  always_comb begin
    prod_rnd = prod_r + D_HALF;
    dist_nxt = prod_rnd[DIST_SHIFT+DIST_W-1:DIST_SHIFT];
    if (cfg.port_sel >= PORT_W'(NUM_PORTS)) begin
      dist_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      wpos_r    <= '0;
      wrapped_r <= 1'b0;
      rnd_r     <= '0;
      j_r       <= '0;
    end else begin
      if (cmd.ring) begin
        sum_r     <= sum_nxt;
        wpos_r    <= wpos_nxt;
        wrapped_r <= wrapped_nxt;
      end
      if (cmd.norm) begin
        rnd_r <= '0;
      end else if (cmd.log_step) begin
        rnd_r <= rnd_nxt;
      end
      if (cmd.t_mul) begin
        j_r <= TERM_ONE;
      end else if (cmd.term_acc) begin
        j_r <= j_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      smp_r <= in_sample;
    end
    if (cmd.mean) begin
      mean_r <= mean_nxt;
      lvl_r  <= lvl_nxt;
    end
    if (cmd.index) begin
      x_r <= x_nxt;
    end
    if (cmd.norm) begin
      n_r    <= msb;
      m_r    <= M_W'(x_r) << (M_W - 1 - int'(msb));
      frac_r <= '0;
    end else if (cmd.log_step) begin
      m_r    <= m_nxt;
      frac_r <= frac_nxt;
    end
    if (cmd.exp_mul) begin
      e_r <= e_sum[EPROD_W-1:E_SHIFT];
    end
    if (cmd.t_mul) begin
      t_r    <= mul_p[F_W+Q32_W-1:F_W];
      term_r <= mul_p[F_W+Q32_W-1:F_W];
      acc_r  <= ACC_ONE;
    end else if (cmd.term_cor) begin
      term_r <= term_nxt;
    end
    if (cmd.term_acc) begin
      acc_r <= acc_nxt;
    end
    if (cmd.term_mul) begin
      p_r <= mul_p[2*Q32_W-1:Q32_W];
    end
    if (cmd.term_rcp) begin
      q0_r <= mul_p[2*Q32_W-1:Q32_W];
    end
    if (cmd.fin_y) begin
      omy_r <= OMY_ONE - y_cl;
    end
    if (cmd.fin_mul) begin
      prod_r <= mul_p[PROD_W-1:0];
    end
    if (cmd.fin_rnd) begin
      dist_r <= dist_nxt;
    end
    if (cmd.load_out) begin
      out_dist_r <= dist_r;
      out_avg_r  <= mean_r;
    end
  end

  assign stat.log_last  = (rnd_r == LOG_LAST);
  assign stat.term_last = (j_r == TERM_LAST);

  assign out_item.distance       = out_dist_r;
  assign out_item.averaged_level = out_avg_r;
endmodule

/* src/hall_sensor_distance_linearizer.sv */
// Items are taken one at a time: a new item is accepted only once the last is done, as
// the 16-round log2 squaring loop and the 14-term exponential series (multiply, reciprocal
// multiply, correct, accumulate per term) run in turn, their wide products all through one
// shared 33x32 multiplier. A waiting result blocks intake only once the following item has
// also finished. Reset: control, configuration, ring and loop-counter registers take their
// defaults; the sample ring reads as zero until the write pointer wraps once, so no
// clearing pass is needed.
module hall_sensor_distance_linearizer
  import hsdl_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hsdl_stream_if.sink           in_ch,
  hsdl_stream_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  cfg_t      cfg;
  cmd_t      cmd;
  stat_t     stat;
  in_item_t  in_item;
  out_item_t out_item;
  logic      in_ready;
  logic      out_valid;

  assign in_item      = in_ch.data;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  hsdl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hsdl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hsdl_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .in_sample (in_item.sample),
    .out_item  (out_item)
  );
endmodule

/* tb/testbench.sv */
// Self-checking testbench of the hall sensor distance linearizer: directed table, then random.
module testbench;
  import hsdl_pkg::*;

  localparam int RING_LEN    = WINDOW_DEF;
  localparam int ITEM_TARGET = 1050;
  localparam int HOLD_CYCLES = 1200;
  localparam int STALL_LIMIT = 6000;
  localparam int DRAIN_TAIL  = 100;
  localparam int PORT_COUNT  = 5;

  localparam longint unsigned ONE_Q32 = 64'h1_0000_0000;
  localparam longint unsigned LN2_FIX = 64'd2977044472;

  // Calibrated pairs: a in millionths, |b| in units of 1e-8.
  localparam longint unsigned SCALE_MICRO [PORT_COUNT] =
    '{64'd45958904, 64'd45426605, 64'd45757970, 64'd45373700, 64'd46212210};
  localparam longint unsigned EXPO_E8 [PORT_COUNT] =
    '{64'd44967207, 64'd44433630, 64'd44760870, 64'd44436312, 64'd45146140};

  localparam cfg_t RESET_CFG = '{3'd0, 12'd0, 12'd4095, 12'd4095};

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_e;
  typedef enum int {TAKE_ALWAYS, TAKE_COIN, TAKE_MOSTLY, TAKE_PERIODIC} sink_mode_e;
  typedef enum int {WAVE_DRIFT, WAVE_UNIFORM, WAVE_RAILS, WAVE_STEADY} wave_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_t              cfg;
    logic [SMP_W-1:0]  sample;
    logic [4:0]        reps;
    bit                mean_known;
    logic [LVL_W-1:0]  mean;
    bit                dist_known;
    logic [DIST_W-1:0] dist_want;
  } plan_row_t;

  localparam int PLAN_LEN = 19;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_ITEM, '0, 12'd0, 5'd1, 1'b1, 12'd0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 12'd4095, 5'd15, 1'b0, 12'd0, 1'b0, 16'd0},
    '{ROW_ITEM, '0, 12'd4095, 5'd1, 1'b1, 12'd4095, 1'b0, 16'd0},
    '{ROW_CFG, '{3'd5, 12'd0, 12'd4095, 12'd4095}, '0, '0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 5'd1, 1'b1, 12'd4095, 1'b1, 16'd0},
    '{ROW_CFG, '{3'd7, 12'd0, 12'd4095, 12'd4095}, '0, '0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, 12'd0, 5'd1, 1'b1, 12'd3839, 1'b1, 16'd0},
    '{ROW_CFG, '{3'd4, 12'd4095, 12'd0, 12'd4095}, '0, '0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, 12'd2048, 5'd1, 1'b0, 12'd0, 1'b0, 16'd0},
    '{ROW_CFG, '{3'd0, 12'd100, 12'd3000, 12'd150}, '0, '0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 5'd1, 1'b0, 12'd0, 1'b0, 16'd0},
    '{ROW_CFG, '{3'd1, 12'd2000, 12'd4095, 12'd1000}, '0, '0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, 12'd0, 5'd1, 1'b0, 12'd0, 1'b0, 16'd0},
    '{ROW_CFG, '{3'd2, 12'd0, 12'd0, 12'd4095}, '0, '0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, 12'd1234, 5'd1, 1'b0, 12'd0, 1'b0, 16'd0},
    '{ROW_CFG, '{3'd3, 12'd4095, 12'd4095, 12'd4095}, '0, '0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, 12'd4095, 5'd1, 1'b0, 12'd0, 1'b0, 16'd0},
    '{ROW_CFG, '{3'd4, 12'd0, 12'd4095, 12'd4095}, '0, '0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, 12'd0, 5'd1, 1'b0, 12'd0, 1'b0, 16'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hsdl_stream_if #(.item_t(in_item_t))  in_ch ();
  hsdl_stream_if #(.item_t(out_item_t)) out_ch ();

  hall_sensor_distance_linearizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's window and registers.
  logic [SMP_W-1:0] window_ring [RING_LEN];
  logic [15:0]      window_sum;
  int               window_pos;
  cfg_t             live_cfg;

  out_item_t pending_readings [$];
  int items_sent;
  int results_seen;
  int settings_written;
  int errors;
  int hold_requests;
  int burst_left;

  function automatic logic [LOG_W-1:0] log2_q4_16(input int unsigned x);
    int unsigned     n;
    longint unsigned m;
    logic [15:0]     frac;
    n = 0;
    while (n < 31 && (x >> (n + 1)) != 0) n++;
    m = x;
    m = m << (30 - n);
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = {frac[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {n[3:0], frac};
  endfunction

  // 2^-f for f in Q.24 by the Taylor series of exp(-f*ln2), result in Q0.32.
  function automatic longint unsigned exp2_neg_q32(input longint unsigned f);
    longint unsigned t;
    longint unsigned term;
    longint          acc;
    t = (f * LN2_FIX) >> 24;
    term = ONE_Q32;
    acc = longint'(ONE_Q32);
    for (int unsigned j = 1; j <= 14; j++) begin
      term = ((term * t) >> 32) / j;
      if (j % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return $unsigned(acc);
  endfunction

  function automatic logic [DIST_W-1:0] power_curve(input logic [PORT_W-1:0] port,
                                                   input int unsigned x);
    longint unsigned a, b, e, k, y, prod;
    prod = '0;
    if (port < PORT_COUNT) begin
      a = ((SCALE_MICRO[port] << 24) + 64'd500000) / 64'd1000000;
      b = ((EXPO_E8[port] << 24) + 64'd50000000) / 64'd100000000;
      e = (b * log2_q4_16(x) + 64'd32768) >> 16;
      k = e >> 24;
      if (k > 31) k = 31;
      y = exp2_neg_q32(e & 64'hFF_FFFF) >> k;
      if (y > ONE_Q32) y = ONE_Q32;
      prod = (a * (ONE_Q32 - y) + (64'd1 << 45)) >> 46;
    end
    return prod[DIST_W-1:0];
  endfunction

  // Pushes one sample into the window and works out the reading it produces.
  function automatic out_item_t predict_reading(input logic [SMP_W-1:0] s);
    out_item_t        r;
    logic [LVL_W-1:0] mean;
    int               lvl, idx, lo, hi, top;
    window_sum = window_sum - window_ring[window_pos] + s;
    window_ring[window_pos] = s;
    window_pos = (window_pos + 1) % RING_LEN;
    mean = LVL_W'(window_sum / RING_LEN);
    lo = int'(live_cfg.min_lvl);
    hi = int'(live_cfg.max_lvl);
    top = int'(live_cfg.opmax_lvl);
    lvl = int'(mean);
    if (lvl < lo) lvl = lo;
    if (lvl > top) lvl = top;
    idx = lvl - lo + 1;
    if (lvl >= hi) idx = hi - lo + 1;
    if (idx < 1) idx = 1;
    if (idx > 4096) idx = 4096;
    r.distance = power_curve(live_cfg.port_sel, idx + 3);
    r.averaged_level = mean;
    return r;
  endfunction

  function automatic int clamp12(input int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (pending_readings.size() == 0) begin
      $error("unexpected result: distance %0d averaged_level %0d",
             got.distance, got.averaged_level);
      errors++;
    end else begin
      want = pending_readings.pop_front();
      if (got.distance !== want.distance) begin
        $error("distance: expected %0d, got %0d", want.distance, got.distance);
        errors++;
      end
      if (got.averaged_level !== want.averaged_level) begin
        $error("averaged_level: expected %0d, got %0d",
               want.averaged_level, got.averaged_level);
        errors++;
      end
    end
  endtask

  task automatic send_item(input logic [SMP_W-1:0] s,
                           input bit mean_known = 1'b0, input logic [LVL_W-1:0] mean_val = '0,
                           input bit dist_known = 1'b0, input logic [DIST_W-1:0] dist_val = '0);
    out_item_t want;
    in_ch.valid <= 1'b1;
    in_ch.data.sample <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = predict_reading(s);
    if (mean_known) want.averaged_level = mean_val;
    if (dist_known) want.distance = dist_val;
    pending_readings.push_back(want);
    items_sent++;
  endtask

  // The sender works in bursts; a burst ends with a gap of random length, sometimes none.
  task automatic pace();
    int gap;
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // All four registers in consecutive cycles; the port select sometimes carries junk above bit 2.
  task automatic write_regs(input cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PORT_SELECT;
    cfg_wdata <= {($urandom_range(0, 1) != 0) ? 9'($urandom) : 9'd0, c.port_sel};
    @(posedge clk);
    cfg_index <= CFG_MIN_LEVEL;
    cfg_wdata <= c.min_lvl;
    @(posedge clk);
    cfg_index <= CFG_MAX_LEVEL;
    cfg_wdata <= c.max_lvl;
    @(posedge clk);
    cfg_index <= CFG_OP_MAX_LEVEL;
    cfg_wdata <= c.opmax_lvl;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_cfg = c;
    settings_written++;
  endtask

  initial begin : stimulus
    cfg_t             c;
    wave_e            wave;
    int               phase, phase_items, level, pick, lo, hi;
    bit               pressure;
    logic [SMP_W-1:0] smp;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PORT_SELECT;
    cfg_wdata = '0;
    for (int i = 0; i < RING_LEN; i++) window_ring[i] = '0;
    window_sum = '0;
    window_pos = 0;
    live_cfg = RESET_CFG;
    items_sent = 0;
    settings_written = 0;
    hold_requests = 0;
    burst_left = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].kind == ROW_CFG) begin
        quiesce();
        write_regs(PLAN[r].cfg);
      end else begin
        repeat (PLAN[r].reps) begin
          send_item(PLAN[r].sample, PLAN[r].mean_known, PLAN[r].mean,
                    PLAN[r].dist_known, PLAN[r].dist_want);
          pace();
        end
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 5)
        0: begin
          pick = $urandom_range(0, 3);
          c.min_lvl   = (pick == 2) ? 12'd4095 : 12'd0;
          c.max_lvl   = (pick == 1) ? 12'd0 : 12'd4095;
          c.opmax_lvl = (pick == 3) ? 12'd0 : (pick == 1) ? 12'd0 : 12'd4095;
        end
        4: begin
          c.min_lvl   = LVL_W'($urandom_range(0, 4095));
          c.max_lvl   = LVL_W'($urandom_range(0, 4095));
          c.opmax_lvl = LVL_W'($urandom_range(0, 4095));
        end
        default: begin
          lo = $urandom_range(0, 3000);
          hi = $urandom_range(lo, 4095);
          c.min_lvl   = LVL_W'(lo);
          c.max_lvl   = LVL_W'(hi);
          c.opmax_lvl = LVL_W'($urandom_range(lo, 4095));
        end
      endcase
      c.port_sel = ($urandom_range(0, 5) == 0) ? PORT_W'($urandom_range(5, 7))
                                                : PORT_W'($urandom_range(0, 4));
      quiesce();
      write_regs(c);

      // Twice the receiver holds off while items keep coming with no gaps.
      pressure = (phase == 1 || phase == 6);
      if (pressure) hold_requests <= hold_requests + 1;

      pick = $urandom_range(0, 9);
      wave = (pick < 6) ? WAVE_DRIFT : (pick < 8) ? WAVE_UNIFORM :
             (pick < 9) ? WAVE_RAILS : WAVE_STEADY;
      case ($urandom_range(0, 3))
        0: level = int'(c.min_lvl);
        1: level = int'(c.max_lvl);
        2: level = int'(c.opmax_lvl);
        default: level = $urandom_range(0, 4095);
      endcase
      level = clamp12(level + int'($urandom_range(0, 128)) - 64);
      phase_items = $urandom_range(40, 110);

      repeat (phase_items) begin
        case (wave)
          WAVE_DRIFT: begin
            level = clamp12(level + int'($urandom_range(0, 80)) - 40);
            smp = SMP_W'(clamp12(level + int'($urandom_range(0, 16)) - 8));
          end
          WAVE_UNIFORM: smp = SMP_W'($urandom_range(0, 4095));
          WAVE_RAILS:   smp = ($urandom_range(0, 1) != 0) ? 12'd4095 : 12'd0;
          default:      smp = SMP_W'(level);
        endcase
        send_item(smp);
        if (!pressure) pace();
      end
      phase++;
    end

    quiesce();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Sent %0d samples and checked %0d readings across %0d register settings,",
             items_sent, results_seen, settings_written);
    $display("including all five curves, unused ports, inverted limits and a long sink stall.");
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left, hold_left, holds_served, period, tick;
    logic       take;
    out_ch.ready = 1'b0;
    errors = 0;
    results_seen = 0;
    mode = TAKE_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    holds_served = 0;
    period = 2;
    tick = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        check_result(out_ch.data);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 800);
        period = $urandom_range(2, 160);
      end
      mode_left--;
      tick++;
      case (mode)
        TAKE_ALWAYS: take = 1'b1;
        TAKE_COIN:   take = ($urandom_range(0, 1) != 0);
        TAKE_MOSTLY: take = ($urandom_range(0, 3) != 0);
        default:     take = ((tick % period) < period / 2);
      endcase
      if (hold_left != 0) begin
        take = 1'b0;
        hold_left--;
      end
      out_ch.ready <= take;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $error("no item moved on either channel for %0d cycles", STALL_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
src/hsdl_pkg.sv
src/hsdl_stream_if.sv
src/hsdl_ram.sv
src/hsdl_cfg_regs.sv
src/hsdl_ctrl.sv
src/hsdl_dp.sv
src/hall_sensor_distance_linearizer.sv
tb/testbench.sv
